// File: rtl/ffa_pkg.sv
// Package for the first-fit aligned allocator: request and response types,
// status codes and default parameter values. No dependencies.
`default_nettype none

package ffa_pkg;

    localparam int unsigned DEF_MAX_EXTENTS = 32;
    localparam int unsigned DEF_ADDR_BITS   = 32;

    // Pool size loaded at reset.
    localparam logic [31:0] RESET_POOL = 32'd65536;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] req_size;
        logic [4:0]  align_log2;
        logic [31:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] alloc_offset;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/ffa_ext_ram.sv
// Extent table storage: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module ffa_ext_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ffa_fit_chk.sv
// Fit check for one extent against an aligned allocate request, and the
// trimmed extent that results. Depends on nothing but its parameters.
`default_nettype none

module ffa_fit_chk #(
    parameter int unsigned ADDR_BITS = 32
) (
    input  wire logic [ADDR_BITS-1:0] i_start,
    input  wire logic [ADDR_BITS-1:0] i_length,
    input  wire logic [ADDR_BITS-1:0] i_size,
    input  wire logic [4:0]           i_align_log2,
    output logic                      o_fit,
    output logic [ADDR_BITS-1:0]      o_at,
    output logic [ADDR_BITS-1:0]      o_new_start,
    output logic [ADDR_BITS-1:0]      o_new_length
);

    localparam int unsigned XW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;

    logic [31:0]    align_mask;
    logic [31:0]    start_lo;
    logic [31:0]    pad;
    logic [63:0]    start_w;
    logic [XW-1:0]  pad_x;
    logic [XW-1:0]  size_x;
    logic [XW-1:0]  len_x;
    logic [XW-1:0]  start_x;
    logic [XW-1:0]  need_x;
    logic [XW-1:0]  at_x;
    logic [ADDR_BITS-1:0] pad_t;

    always_comb begin
        start_w = '0;
        start_w[ADDR_BITS-1:0] = i_start;
        align_mask = (32'd1 << i_align_log2) - 32'd1;
        start_lo = start_w[31:0] & align_mask;
        pad = (32'd0 - start_lo) & align_mask;
        pad_x = {{(XW-32){1'b0}}, pad};
        size_x = {{(XW-ADDR_BITS){1'b0}}, i_size};
        len_x = {{(XW-ADDR_BITS){1'b0}}, i_length};
        start_x = {{(XW-ADDR_BITS){1'b0}}, i_start};
        need_x = pad_x + size_x;
        o_fit = (len_x >= need_x);
        at_x = start_x + pad_x;
        o_at = at_x[ADDR_BITS-1:0];
        pad_t = pad_x[ADDR_BITS-1:0];
        o_new_start = o_at + i_size;
        o_new_length = i_length - pad_t - i_size;
    end

endmodule

`default_nettype wire

// File: rtl/first_fit_aligned_allocator.sv
// Top level of the first-fit aligned allocator: request sequencer around the
// extent table memory. Depends on ffa_pkg, ffa_ext_ram and ffa_fit_chk.
//
//   Channel    Direction  Handshake                  Payload
//   request    in         i_req_valid / o_req_ready  i_req  (ffa_pkg::t_req)
//   response   out        o_rsp_valid / i_rsp_ready  o_rsp  (ffa_pkg::t_rsp)
//   config     in         i_cfg_we (no wait)         i_cfg_wdata (pool size)
//
// One transaction is worked on at a time. An allocate scans the table from
// entry 0 for the first fit; when that entry empties, the rest of the table
// moves down one place. A free merges the old entries and the freed extent
// in start order. The single read port of the table memory reads one entry
// per cycle, but a free holds its reads while the freed extent goes in.
// Reset is synchronous; the S_INIT step then seeds entry 0 with the default
// pool. A waiting response sits in the output register while the next
// request is accepted; the sequencer only stalls at its final step.
`default_nettype none

module first_fit_aligned_allocator #(
    parameter int unsigned MAX_EXTENTS = ffa_pkg::DEF_MAX_EXTENTS,
    parameter int unsigned ADDR_BITS   = ffa_pkg::DEF_ADDR_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire ffa_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output ffa_pkg::t_rsp      o_rsp,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata
);

    import ffa_pkg::*;

    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
    localparam int unsigned AW = ADDR_BITS;
    localparam logic [63:0]    RESET_POOL_W = {32'd0, RESET_POOL};
    localparam logic [AW-1:0]  RESET_LEN    = RESET_POOL_W[AW-1:0];

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FREE,
        S_DONE
    } t_state;

    // Sequencer registers.
    t_state        r_state,   n_state;
    logic [CW-1:0] r_cnt,     n_cnt;
    logic [CW-1:0] r_rd_idx,  n_rd_idx;
    logic          r_dv,      n_dv;
    logic [IW-1:0] r_dv_idx,  n_dv_idx;
    logic [CW-1:0] r_wr_idx,  n_wr_idx;
    logic          r_have,    n_have;
    logic          r_ins,     n_ins;
    logic [AW-1:0] r_cur_s,   n_cur_s;
    logic [AW-1:0] r_cur_l,   n_cur_l;
    logic [AW-1:0] r_size,    n_size;
    logic [AW-1:0] r_off,     n_off;
    logic [4:0]    r_align,   n_align;
    logic [1:0]    r_status,  n_status;
    logic [AW-1:0] r_grant,   n_grant;
    logic          r_rsp_vld, n_rsp_vld;
    t_rsp          r_rsp,     n_rsp;

    // Table memory port.
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [2*AW-1:0] mem_wdata;
    logic            mem_re;
    logic [2*AW-1:0] mem_rdata;

    ffa_ext_ram #(
        .DEPTH (MAX_EXTENTS),
        .WIDTH (2 * AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (mem_rdata)
    );

    logic [AW-1:0] e_s;
    logic [AW-1:0] e_l;
    assign e_s = mem_rdata[2*AW-1:AW];
    assign e_l = mem_rdata[AW-1:0];

    logic          fit;
    logic [AW-1:0] fit_at;
    logic [AW-1:0] fit_new_s;
    logic [AW-1:0] fit_new_l;

    ffa_fit_chk #(
        .ADDR_BITS (AW)
    ) u_fit (
        .i_start      (e_s),
        .i_length     (e_l),
        .i_size       (r_size),
        .i_align_log2 (r_align),
        .o_fit        (fit),
        .o_at         (fit_at),
        .o_new_start  (fit_new_s),
        .o_new_length (fit_new_l)
    );

    // Input and configuration values cut or widened to the address width.
    logic [63:0]   in_size_w;
    logic [63:0]   in_off_w;
    logic [63:0]   cfg_w;
    logic [63:0]   grant_w;
    logic [AW-1:0] in_size;
    logic [AW-1:0] in_off;
    logic [AW-1:0] cfg_len;

    always_comb begin
        in_size_w = {32'd0, i_req.req_size};
        in_off_w  = {32'd0, i_req.free_offset};
        cfg_w     = {32'd0, i_cfg_wdata};
        in_size   = in_size_w[AW-1:0];
        in_off    = in_off_w[AW-1:0];
        cfg_len   = cfg_w[AW-1:0];
        grant_w   = '0;
        grant_w[AW-1:0] = r_grant;
    end

    // Merge stream: the next element in start order and whether it touches
    // the extent being accumulated.
    logic          rd_more;
    logic          ins_now;
    logic          cons_old;
    logic          elem_v;
    logic [AW-1:0] elem_s;
    logic [AW-1:0] elem_l;
    logic [AW:0]   cur_end;
    logic [AW:0]   cur_sum;
    logic          touch;
    logic [AW-1:0] merged_l;

    always_comb begin
        rd_more  = (r_rd_idx < r_cnt);
        ins_now  = !r_ins && (r_dv ? (e_s > r_off) : !rd_more);
        cons_old = r_dv && !ins_now;
        elem_v   = ins_now || cons_old;
        elem_s   = ins_now ? r_off  : e_s;
        elem_l   = ins_now ? r_size : e_l;
        cur_end  = {1'b0, r_cur_s} + {1'b0, r_cur_l};
        touch    = !cur_end[AW] && (cur_end[AW-1:0] == elem_s);
        cur_sum  = {1'b0, r_cur_l} + {1'b0, elem_l};
        merged_l = cur_sum[AW] ? {AW{1'b1}} : cur_sum[AW-1:0];
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rd_idx  = r_rd_idx;
        n_dv      = r_dv;
        n_dv_idx  = r_dv_idx;
        n_wr_idx  = r_wr_idx;
        n_have    = r_have;
        n_ins     = r_ins;
        n_cur_s   = r_cur_s;
        n_cur_l   = r_cur_l;
        n_size    = r_size;
        n_off     = r_off;
        n_align   = r_align;
        n_status  = r_status;
        n_grant   = r_grant;
        n_rsp_vld = r_rsp_vld && !i_rsp_ready;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // Seed entry 0 with the default pool after reset.
                mem_we    = 1'b1;
                mem_wdata = {{AW{1'b0}}, RESET_LEN};
                n_state   = S_IDLE;
            end

            S_IDLE: begin
                if (i_req_valid) begin
                    n_size   = in_size;
                    n_off    = in_off;
                    n_align  = i_req.align_log2;
                    n_rd_idx = '0;
                    n_dv     = 1'b0;
                    n_wr_idx = '0;
                    n_have   = 1'b0;
                    n_ins    = 1'b0;
                    n_grant  = '0;
                    n_status = ST_OK;
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (r_cnt == '0) begin
                            n_status = ST_NOFIT;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (in_size == '0) begin
                            n_state = S_DONE;
                        end else if (r_cnt == CW'(MAX_EXTENTS)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_FREE;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Read one entry per cycle and test the one read last cycle.
                if (rd_more) begin
                    mem_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (fit) begin
                        n_grant = fit_at;
                        if (fit_new_l != '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_dv_idx;
                            mem_wdata = {fit_new_s, fit_new_l};
                            n_state   = S_DONE;
                        end else begin
                            // The entry is used up: close the gap.
                            n_rd_idx = CW'(r_dv_idx) + CW'(1);
                            n_dv     = 1'b0;
                            n_state  = S_SHIFT;
                        end
                    end else if (CW'(r_dv_idx) + CW'(1) == r_cnt) begin
                        n_status = ST_NOFIT;
                        n_state  = S_DONE;
                    end
                end
            end

            S_SHIFT: begin
                if (rd_more) begin
                    mem_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_dv_idx - IW'(1);
                    mem_wdata = mem_rdata;
                end
                if (!rd_more && !r_dv) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_FREE: begin
                // Old entries and the freed extent stream through in start
                // order; touching neighbors fold into the accumulated extent.
                if (rd_more && (!r_dv || cons_old)) begin
                    mem_re   = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_dv     = 1'b1;
                end else if (cons_old) begin
                    n_dv = 1'b0;
                end
                if (ins_now) begin
                    n_ins = 1'b1;
                end
                if (elem_v) begin
                    if (!r_have) begin
                        n_have  = 1'b1;
                        n_cur_s = elem_s;
                        n_cur_l = elem_l;
                    end else if (touch) begin
                        n_cur_l = merged_l;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wr_idx[IW-1:0];
                        mem_wdata = {r_cur_s, r_cur_l};
                        n_wr_idx  = r_wr_idx + CW'(1);
                        n_cur_s   = elem_s;
                        n_cur_l   = elem_l;
                    end
                end else if (r_ins && !rd_more && !r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_idx[IW-1:0];
                    mem_wdata = {r_cur_s, r_cur_l};
                    n_cnt     = r_wr_idx + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_rsp_vld || i_rsp_ready) begin
                    n_rsp_vld = 1'b1;
                    n_rsp.status = r_status;
                    n_rsp.alloc_offset = (r_status == ST_OK) ? grant_w[31:0] : 32'd0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A pool size write rebuilds the table as one extent from zero (empty if zero).
        if (i_cfg_we) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {{AW{1'b0}}, cfg_len};
            n_cnt     = (cfg_len != '0) ? CW'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= (RESET_LEN != '0) ? CW'(1) : '0;
            r_rd_idx  <= '0;
            r_dv      <= 1'b0;
            r_wr_idx  <= '0;
            r_have    <= 1'b0;
            r_ins     <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_idx  <= n_rd_idx;
            r_dv      <= n_dv;
            r_wr_idx  <= n_wr_idx;
            r_have    <= n_have;
            r_ins     <= n_ins;
            r_rsp_vld <= n_rsp_vld;
        end
        r_dv_idx <= n_dv_idx;
        r_cur_s  <= n_cur_s;
        r_cur_l  <= n_cur_l;
        r_size   <= n_size;
        r_off    <= n_off;
        r_align  <= n_align;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_rsp    <= n_rsp;
    end

`ifndef SYNTHESIS
    // The table never holds more entries than the memory has rows.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_EXTENTS))
        else $error("extent count exceeds table depth");

    // While old entries are still to be read, compaction writes stay behind
    // the read pointer.
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !i_cfg_we && r_state == S_FREE && rd_more)
            |-> (r_wr_idx < r_rd_idx))
        else $error("merge write overtook the read pointer");

    // A response only appears from the final step of a transaction.
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !$past(o_rsp_valid && !i_rsp_ready))
            |-> $past(r_state == S_DONE))
        else $error("response raised outside the final step");
`endif

endmodule

`default_nettype wire

// File: dv/first_fit_aligned_allocator_test.sv
// Self-checking testbench for the first-fit aligned allocator.
// Depends on ffa_pkg and the first_fit_aligned_allocator RTL only.
`default_nettype none

module first_fit_aligned_allocator_test;
    import ffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = DEF_MAX_EXTENTS;
    // Idle cycles that cover the longest free or allocate with a full table.
    localparam int unsigned SETTLE_CYCLES = 3 * DEPTH + 20;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] size;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    t_rsp        o_rsp;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    // Predicted state of the free table.
    logic [31:0] free_start [DEPTH];
    logic [31:0] free_len   [DEPTH];
    int unsigned free_count;

    t_rsp   expected_rsp [$];
    t_grant live_grants  [$];
    int     error_count;
    bit     rsp_stall_en;
    int     rsp_stall_left;

    first_fit_aligned_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The table restarts as one extent spanning the pool, or empty for a zero pool.
    function automatic void reload_pool(logic [31:0] pool);
        free_count = 0;
        if (pool != 0) begin
            free_start[0] = '0;
            free_len[0]   = pool;
            free_count    = 1;
        end
    endfunction

    function automatic void drop_extent(int unsigned idx);
        for (int unsigned k = idx; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k + 1];
            free_len[k]   = free_len[k + 1];
        end
        free_count--;
    endfunction

    // First fit: the padding below the aligned start is thrown away together
    // with the granted bytes.
    function automatic t_rsp predict_alloc(logic [31:0] size, logic [4:0] align_log2);
        t_rsp        rsp;
        logic [63:0] align;
        logic [63:0] pad;
        logic [63:0] start;
        logic [63:0] len;
        logic [31:0] granted;
        rsp.status       = ST_NOFIT;
        rsp.alloc_offset = '0;
        align = 64'd1 << align_log2;
        for (int unsigned k = 0; k < free_count; k++) begin
            start = {32'd0, free_start[k]};
            len   = {32'd0, free_len[k]};
            pad   = (align - (start & (align - 1))) & (align - 1);
            if (len >= pad && len - pad >= {32'd0, size}) begin
                granted          = 32'(start + pad);
                rsp.status       = ST_OK;
                rsp.alloc_offset = granted;
                free_start[k]    = granted + size;
                free_len[k]      = 32'(len - pad - size);
                if (free_len[k] == 0) drop_extent(k);
                return rsp;
            end
        end
        return rsp;
    endfunction

    // Sorted insert after equal starts, then one coalescing sweep. An extent
    // that wraps past the top touches nothing; merged lengths saturate.
    function automatic t_rsp predict_free(logic [31:0] offset, logic [31:0] size);
        t_rsp        rsp;
        int unsigned pos;
        int unsigned k;
        logic [32:0] end_addr;
        logic [32:0] sum;
        rsp.status       = ST_OK;
        rsp.alloc_offset = '0;
        if (size == 0) return rsp;
        if (free_count >= DEPTH) begin
            rsp.status = ST_FULL;
            return rsp;
        end
        pos = 0;
        while (pos < free_count && free_start[pos] <= offset) pos++;
        for (k = free_count; k > pos; k--) begin
            free_start[k] = free_start[k - 1];
            free_len[k]   = free_len[k - 1];
        end
        free_start[pos] = offset;
        free_len[pos]   = size;
        free_count++;
        k = 0;
        while (k + 1 < free_count) begin
            end_addr = {1'b0, free_start[k]} + {1'b0, free_len[k]};
            if (!end_addr[32] && end_addr[31:0] == free_start[k + 1]) begin
                sum         = {1'b0, free_len[k]} + {1'b0, free_len[k + 1]};
                free_len[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                drop_extent(k + 1);
            end else begin
                k++;
            end
        end
        return rsp;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got 0x%08h expected 0x%08h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one request and predicts its response once the transaction is
    // accepted. Returns the prediction so tests can track their grants.
    task automatic send_req(input t_req req, input int unsigned gap, output t_rsp rsp);
        t_grant g;
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= req;
        i_req_valid <= 1'b1;
        // Ready only moves at the rising edge, so reading it mid-cycle is safe.
        do @(negedge i_clk); while (!o_req_ready);
        @(posedge i_clk);
        if (req.req_type == REQ_ALLOC) rsp = predict_alloc(req.req_size, req.align_log2);
        else rsp = predict_free(req.free_offset, req.req_size);
        expected_rsp.insert(expected_rsp.size(), rsp);
        if (req.req_type == REQ_ALLOC && rsp.status == ST_OK && req.req_size != 0) begin
            g.offset = rsp.alloc_offset;
            g.size   = req.req_size;
            live_grants.insert(live_grants.size(), g);
        end
    endtask

    task automatic do_alloc(logic [31:0] size, logic [4:0] align_log2, int unsigned gap);
        t_req req;
        t_rsp rsp;
        req.req_type    = REQ_ALLOC;
        req.req_size    = size;
        req.align_log2  = align_log2;
        req.free_offset = $urandom;
        send_req(req, gap, rsp);
    endtask

    task automatic do_free(logic [31:0] offset, logic [31:0] size, int unsigned gap);
        t_req req;
        t_rsp rsp;
        req.req_type    = REQ_FREE;
        req.req_size    = size;
        req.align_log2  = 5'($urandom);
        req.free_offset = offset;
        send_req(req, gap, rsp);
    endtask

    // Releases one tracked grant, picked at random.
    task automatic free_live_grant(int unsigned gap);
        int unsigned idx;
        t_grant      g;
        idx = $urandom_range(live_grants.size() - 1);
        g   = live_grants[idx];
        live_grants.delete(idx);
        do_free(g.offset, g.size, gap);
    endtask

    // Waits until the block is idle, then reloads the pool size.
    task automatic set_pool(logic [31:0] pool);
        i_req_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pool;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reload_pool(pool);
        live_grants.delete();
    endtask

    // Extremes of every field and the named corner cases, on the reset pool.
    task automatic test_directed();
        do_alloc(32'd0, 5'd0, 0);              // zero-size allocate at offset 0
        do_alloc(32'd100, 5'd0, 0);
        do_alloc(32'd64, 5'd6, 1);             // padding is discarded
        do_alloc(32'd1, 5'd31, 0);             // alignment far past the pool
        do_alloc(32'hFFFF_FFFF, 5'd0, 0);      // never fits
        do_alloc(32'd0, 5'd31, 0);
        do_free(32'd0, 32'd0, 0);              // zero-size free is ignored
        do_free(32'd0, 32'd100, 2);            // merges with the padding gap? no, separate
        do_free(32'd0, 32'd100, 0);            // double free kept as overlap
        do_free(32'd100, 32'd28, 0);           // closes the gap up to the 64-byte grant
        do_free(32'd128, 32'd64, 0);
        do_free(32'hFFFF_FFF0, 32'h100, 0);    // wraps past the top
        do_free(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        do_alloc(32'd16, 5'd4, 0);
        do_alloc(32'd65536, 5'd0, 0);
        live_grants.delete();
    endtask

    // Largest pool: merging the top byte onto the whole pool saturates.
    task automatic test_saturation();
        set_pool(32'hFFFF_FFFF);
        do_free(32'hFFFF_FFFF, 32'd5, 0);
        do_alloc(32'hFFFF_FFFF, 5'd0, 0);
        do_alloc(32'd1, 5'd31, 0);
        do_free(32'd0, 32'd1, 0);
        set_pool(32'd1);
        do_alloc(32'd1, 5'd0, 0);
        do_alloc(32'd0, 5'd0, 0);              // empty table
        do_free(32'd0, 32'd1, 0);
    endtask

    // Fragment the table with every other block freed until frees are refused.
    task automatic test_table_full();
        t_grant kept [$];
        set_pool(32'd65536);
        for (int k = 0; k < 80; k++) do_alloc(32'd16, 5'd4, pick_gap());
        kept = live_grants;
        for (int k = 0; k < kept.size(); k += 2) do_free(kept[k].offset, kept[k].size, pick_gap());
        for (int k = 1; k < kept.size(); k += 2) do_free(kept[k].offset, kept[k].size, pick_gap());
        live_grants.delete();
    endtask

    // Mostly allocate and release of real grants, with noise frees mixed in.
    task automatic test_random(logic [31:0] pool, int unsigned items, bit calm);
        int unsigned roll;
        logic [31:0] size;
        logic [4:0]  align_log2;
        set_pool(pool);
        rsp_stall_en = !calm;
        for (int unsigned n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            if (roll < 48 || (roll < 85 && live_grants.size() == 0)) begin
                size       = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 600);
                align_log2 = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(8));
                if ($urandom_range(30) == 0) size = 0;
                do_alloc(size, align_log2, calm ? 0 : pick_gap());
            end else if (roll < 85) begin
                free_live_grant(calm ? 0 : pick_gap());
            end else begin
                do_free($urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 300),
                        calm ? 0 : pick_gap());
            end
        end
        rsp_stall_en = 1'b1;
    endtask

    // Response side: random stalls, and the check of each accepted response.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_rsp_ready    <= 1'b0;
            rsp_stall_left <= 0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected response", 32'(o_rsp.status), 32'd0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                    if (o_rsp.alloc_offset !== want.alloc_offset)
                        report_mismatch("alloc_offset", o_rsp.alloc_offset, want.alloc_offset);
                end
            end
            if (rsp_stall_left > 0) begin
                i_rsp_ready    <= 1'b0;
                rsp_stall_left <= rsp_stall_left - 1;
            end else if (rsp_stall_en && $urandom_range(3) == 0) begin
                i_rsp_ready    <= 1'b0;
                rsp_stall_left <= pick_gap();
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        error_count  = 0;
        rsp_stall_en = 1'b1;
        i_rst_n      = 1'b0;
        i_req_valid  = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        reload_pool(RESET_POOL);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_table_full();
        test_random(32'd65536, 700, 1'b0);
        test_random(32'd4096, 300, 1'b1);
        test_random(32'hFFFF_FFFF, 400, 1'b0);
        test_random(32'd1, 60, 1'b0);
        test_random($urandom_range(1, 32'h0010_0000), 200, 1'b0);

        i_req_valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("first_fit_aligned_allocator_test: clean");
        end else begin
            $display("first_fit_aligned_allocator_test: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("first_fit_aligned_allocator_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
